### hdl/ffsr_pkg.sv
// ----------------------------------------------------------------------------
// ffsr_pkg
// Shared constants and types for the Feige-Fiat-Shamir round unit: default
// word width, register map indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package ffsr_pkg;

	// default operand width
	localparam int WORD_BITS_DEF = 31;

	// register map, index = byte address / register stride
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_MODULUS    = 2'd0;
	localparam reg_idx_t REG_COMMITMENT = 2'd1;
	localparam reg_idx_t REG_WIT_NEG    = 2'd2;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED_R,
		ST_SQ_R,
		ST_RED_S,
		ST_MUL_Y,
		ST_SQ_S,
		ST_MUL_V,
		ST_RED_Y,
		ST_SQ_Y,
		ST_OUT
	} seq_state_t;

endpackage

### hdl/ffsr_horner.sv
// ----------------------------------------------------------------------------
// ffsr_horner
// Bit-serial modular multiply-accumulate unit. Walks the operand from its
// msb down, one bit a cycle: acc = 2*acc + bit*addend mod n. With addend
// already below n this gives addend*operand mod n; with addend = 1 it
// reduces the operand mod n. A modulus below two gives 0.
// ----------------------------------------------------------------------------
module ffsr_horner
	import ffsr_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] addend,
	input  logic [WORD_BITS-1:0] operand,
	input  logic [WORD_BITS-1:0] modulus,
	output logic                 busy,
	output logic                 done,
	output logic [WORD_BITS-1:0] result
);

	localparam int CW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam logic [CW-1:0] LAST_CNT = CW'(WORD_BITS - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] opnd_q;
	logic [WORD_BITS-1:0] add_q;

	logic [WORD_BITS+1:0] sum;
	logic [WORD_BITS+1:0] n1;
	logic [WORD_BITS+1:0] n2;
	logic [WORD_BITS-1:0] acc_d;
	logic                 small_mod;

	// one doubling step with conditional add, then a single range fold
	always_comb begin
		n1        = {2'b00, modulus};
		n2        = {1'b0, modulus, 1'b0};
		small_mod = (modulus[WORD_BITS-1:1] == '0);
		sum       = {1'b0, acc_q, 1'b0}
			+ (opnd_q[WORD_BITS-1] ? {2'b00, add_q} : '0);
		if (small_mod) begin
			acc_d = '0;
		end else if (sum >= n2) begin
			acc_d = WORD_BITS'(sum - n2);
		end else if (sum >= n1) begin
			acc_d = WORD_BITS'(sum - n1);
		end else begin
			acc_d = WORD_BITS'(sum);
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_CNT);
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST_CNT) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			acc_q  <= '0;
			opnd_q <= operand;
			add_q  <= addend;
		end else if (busy_q) begin
			acc_q  <= acc_d;
			opnd_q <= {opnd_q[WORD_BITS-2:0], 1'b0};
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = acc_q;

endmodule

### hdl/feige_fiat_shamir_round_unit.sv
// Each item runs as modular steps in the shared unit: 2 when it opens a round,
// 4 more when its challenge bit is set, and 2 more plus the output state when
// it closes one.
// Throughput is set by the single bit-serial multiplier; one item at a time.
// Reset (arst_n low) clears sequencer and output valid, and resets config registers.
// ----------------------------------------------------------------------------
// feige_fiat_shamir_round_unit
// One identification round modulo n: witness, response, response squared,
// verifier product and match flag, built from a shared shift-add multiplier.
// ----------------------------------------------------------------------------
module feige_fiat_shamir_round_unit
	import ffsr_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF,
	localparam int DW       = (WORD_BITS > 32) ? 64 : 32,
	localparam int STRIDE   = (WORD_BITS > 32) ? 3 : 2,
	localparam int AW       = STRIDE + 2,
	localparam int IN_TW    = ((WORD_BITS + 1 + 7) / 8) * 8,
	localparam int OUT_TW   = ((4 * WORD_BITS + 1 + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	// apb configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [AW-1:0]     paddr,
	input  logic [DW-1:0]     pwdata,
	output logic [DW-1:0]     prdata,
	output logic              pready,
	// input stream
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [IN_TW-1:0]  s_axis_tdata,  // secret_value, challenge_bit
	input  logic              s_axis_tlast,  // last_secret
	// result stream
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_TW-1:0] m_axis_tdata   // witness, response, response_squared,
	                                         // verifier_product, identity_ok
);

	logic [WORD_BITS-1:0] modulus_q;
	logic [WORD_BITS-1:0] commit_q;
	logic                 wit_neg_q;

	seq_state_t state_q, state_d;
	logic       kick_q;
	logic       first_q;
	logic       m_valid_q;
	logic [OUT_TW-1:0] m_data_q;

	logic [WORD_BITS-1:0] s_q;
	logic                 a_q;
	logic                 last_q;
	logic [WORD_BITS-1:0] tmp_q;
	logic [WORD_BITS-1:0] sq_q;
	logic [WORD_BITS-1:0] wit_q;
	logic [WORD_BITS-1:0] resp_q;
	logic [WORD_BITS-1:0] ver_q;

	logic                 in_xact;
	logic                 cfg_wr;
	reg_idx_t             cfg_idx;
	logic                 out_free;
	logic [WORD_BITS-1:0] hr_addend;
	logic [WORD_BITS-1:0] hr_operand;
	logic                 hr_busy;
	logic                 hr_done;
	logic [WORD_BITS-1:0] hr_result;
	logic [WORD_BITS-1:0] wit_d;
	logic [OUT_TW-1:0]    pack;

	// configuration registers
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[AW-1:STRIDE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= WORD_BITS'(2);
			commit_q  <= '0;
			wit_neg_q <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_MODULUS:    modulus_q <= pwdata[WORD_BITS-1:0];
				REG_COMMITMENT: commit_q  <= pwdata[WORD_BITS-1:0];
				REG_WIT_NEG:    wit_neg_q <= pwdata[0];
				default:        ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (cfg_idx)
			REG_MODULUS:    prdata = DW'(modulus_q);
			REG_COMMITMENT: prdata = DW'(commit_q);
			REG_WIT_NEG:    prdata = DW'(wit_neg_q);
			default:        prdata = '0;
		endcase
	end

	// handshakes
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xact       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// shared unit operand selection
	always_comb begin
		case (state_q)
			ST_RED_R: begin hr_addend = WORD_BITS'(1); hr_operand = commit_q; end
			ST_SQ_R:  begin hr_addend = tmp_q;         hr_operand = commit_q; end
			ST_RED_S: begin hr_addend = WORD_BITS'(1); hr_operand = s_q;      end
			ST_MUL_Y: begin hr_addend = tmp_q;         hr_operand = resp_q;   end
			ST_SQ_S:  begin hr_addend = tmp_q;         hr_operand = s_q;      end
			ST_MUL_V: begin hr_addend = sq_q;          hr_operand = ver_q;    end
			ST_RED_Y: begin hr_addend = WORD_BITS'(1); hr_operand = resp_q;   end
			ST_SQ_Y:  begin hr_addend = tmp_q;         hr_operand = resp_q;   end
			default:  begin hr_addend = '0;            hr_operand = '0;       end
		endcase
	end

	ffsr_horner #(
		.WORD_BITS (WORD_BITS)
	) u_horner (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (kick_q),
		.addend  (hr_addend),
		.operand (hr_operand),
		.modulus (modulus_q),
		.busy    (hr_busy),
		.done    (hr_done),
		.result  (hr_result)
	);

	// signed witness: n - r^2 when negation is set and r^2 is nonzero, else r^2
	assign wit_d = (wit_neg_q && (hr_result != '0)) ? (modulus_q - hr_result) : hr_result;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xact) begin
					if (first_q) begin
						state_d = ST_RED_R;
					end else if (s_axis_tdata[WORD_BITS]) begin
						state_d = ST_RED_S;
					end else if (s_axis_tlast) begin
						state_d = ST_RED_Y;
					end
				end
			end
			ST_RED_R: if (hr_done) state_d = ST_SQ_R;
			ST_SQ_R: begin
				if (hr_done) begin
					state_d = a_q ? ST_RED_S : (last_q ? ST_RED_Y : ST_IDLE);
				end
			end
			ST_RED_S: if (hr_done) state_d = ST_MUL_Y;
			ST_MUL_Y: if (hr_done) state_d = ST_SQ_S;
			ST_SQ_S:  if (hr_done) state_d = ST_MUL_V;
			ST_MUL_V: if (hr_done) state_d = last_q ? ST_RED_Y : ST_IDLE;
			ST_RED_Y: if (hr_done) state_d = ST_SQ_Y;
			ST_SQ_Y:  if (hr_done) state_d = ST_OUT;
			ST_OUT:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			kick_q    <= 1'b0;
			first_q   <= 1'b1;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kick_q  <= (state_d != state_q) && (state_d != ST_IDLE) && (state_d != ST_OUT);
			if (state_q == ST_SQ_R && hr_done) begin
				first_q <= 1'b0;
			end
			if (state_q == ST_OUT && out_free) begin
				first_q   <= 1'b1;
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// result packing, lowest field first
	always_comb begin
		pack = '0;
		pack[WORD_BITS-1:0]               = wit_q;
		pack[2*WORD_BITS-1:WORD_BITS]     = resp_q;
		pack[3*WORD_BITS-1:2*WORD_BITS]   = sq_q;
		pack[4*WORD_BITS-1:3*WORD_BITS]   = ver_q;
		pack[4*WORD_BITS]                 = (sq_q == ver_q);
	end

	// round datapath registers
	always_ff @(posedge clk) begin
		if (in_xact) begin
			s_q    <= s_axis_tdata[WORD_BITS-1:0];
			a_q    <= s_axis_tdata[WORD_BITS];
			last_q <= s_axis_tlast;
		end
		if (hr_done) begin
			case (state_q)
				ST_RED_R: tmp_q <= hr_result;
				ST_SQ_R: begin
					wit_q  <= wit_d;
					ver_q  <= wit_d;
					resp_q <= tmp_q;
				end
				ST_RED_S: tmp_q  <= hr_result;
				ST_MUL_Y: resp_q <= hr_result;
				ST_SQ_S:  sq_q   <= hr_result;
				ST_MUL_V: ver_q  <= hr_result;
				ST_RED_Y: tmp_q  <= hr_result;
				ST_SQ_Y:  sq_q   <= hr_result;
				default:  ;
			endcase
		end
		if (state_q == ST_OUT && out_free) begin
			m_data_q <= pack;
		end
	end

	// the shared unit is only started when free
	a_kick_free: assert property (@(posedge clk) disable iff (!arst_n)
		kick_q |-> !hr_busy)
		else $error("multiplier started while busy");

	// the unit runs only while the sequencer sits in a compute state
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_OUT) |-> (!hr_busy && !hr_done))
		else $error("multiplier active outside a compute state");

	// no input taken while the multiplier is still working on an item
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_xact |=> !hr_busy)
		else $error("multiplier busy right after an input transaction");

	// a new result is only loaded after the last item of a round
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> (m_axis_tvalid && first_q))
		else $error("result loaded without closing the round");

endmodule

### tb/ffsr_checker.sv
// ----------------------------------------------------------------------------
// ffsr_checker
// Watches the register port and both streams of the round unit. It keeps its
// own copy of the registers and of the round state, works out the result of
// every closed round and compares it field by field with what the block sends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffsr_checker
	import ffsr_pkg::*;
#(
	parameter int WB     = WORD_BITS_DEF,
	localparam int AW     = ((WB > 32) ? 3 : 2) + 2,
	localparam int DW     = (WB > 32) ? 64 : 32,
	localparam int IN_TW  = ((WB + 1 + 7) / 8) * 8,
	localparam int OUT_TW = ((4 * WB + 1 + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [AW-1:0]     paddr,
	input  logic [DW-1:0]     pwdata,
	input  logic              pready,
	input  logic              s_axis_tvalid,
	input  logic              s_axis_tready,
	input  logic [IN_TW-1:0]  s_axis_tdata,  // secret_value, challenge_bit
	input  logic              s_axis_tlast,  // last_secret
	input  logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	input  logic [OUT_TW-1:0] m_axis_tdata,  // witness, response, response_squared,
	                                         // verifier_product, identity_ok
	output int                fail_count,
	output int                expected_left
);

	typedef logic [WB-1:0] word_t;

	typedef struct {
		word_t witness;
		word_t response;
		word_t response_sq;
		word_t verifier;
		logic  identity_ok;
	} round_result_t;

	// register copy
	word_t cfg_modulus;
	word_t cfg_commit;
	logic  cfg_negate;

	// round state copy
	logic  round_first;
	word_t round_witness;
	word_t round_response;
	word_t round_verifier;

	round_result_t round_results_q[$];
	int            reported;

	// a*b mod n; operands below 2^31 so the product fits in 64 bits
	function automatic word_t mod_mul(input logic [63:0] a, input logic [63:0] b,
	                                  input logic [63:0] n);
		if (n < 2)
			return '0;
		return word_t'(((a % n) * (b % n)) % n);
	endfunction

	// one secret of the round; queues the result when it closes the round
	task automatic advance_round(input word_t secret, input logic chal, input logic last);
		logic [63:0]   n;
		word_t         sq;
		round_result_t res;
		n = 64'(cfg_modulus);
		if (round_first) begin
			sq = mod_mul(64'(cfg_commit), 64'(cfg_commit), n);
			// negated witness, zero stays zero
			if (cfg_negate && sq != 0)
				sq = word_t'(n - 64'(sq));
			round_witness  = sq;
			round_response = (n < 2) ? '0 : word_t'(64'(cfg_commit) % n);
			round_verifier = sq;
			round_first    = 1'b0;
		end
		if (chal) begin
			round_response = mod_mul(64'(round_response), 64'(secret), n);
			round_verifier = mod_mul(64'(round_verifier),
			                         64'(mod_mul(64'(secret), 64'(secret), n)), n);
		end
		if (last) begin
			res.witness     = round_witness;
			res.response    = round_response;
			res.response_sq = mod_mul(64'(round_response), 64'(round_response), n);
			res.verifier    = round_verifier;
			res.identity_ok = (res.response_sq == round_verifier);
			round_results_q.insert(round_results_q.size(), res);
			round_first = 1'b1;
		end
	endtask

	// compare one result transaction with the oldest expected round
	task automatic compare_result(input logic [OUT_TW-1:0] d);
		round_result_t exp_res;
		round_result_t got;
		got.witness     = d[WB-1:0];
		got.response    = d[2*WB-1:WB];
		got.response_sq = d[3*WB-1:2*WB];
		got.verifier    = d[4*WB-1:3*WB];
		got.identity_ok = d[4*WB];
		if (round_results_q.size() == 0) begin
			fail_count++;
			if (reported < 10)
				$display("%0t: result with no round pending: x=%h y=%h y2=%h v=%h ok=%b",
				         $realtime, got.witness, got.response, got.response_sq,
				         got.verifier, got.identity_ok);
			reported++;
		end else begin
			exp_res = round_results_q.pop_front();
			if (got.witness !== exp_res.witness || got.response !== exp_res.response ||
			    got.response_sq !== exp_res.response_sq ||
			    got.verifier !== exp_res.verifier ||
			    got.identity_ok !== exp_res.identity_ok) begin
				fail_count++;
				if (reported < 10) begin
					$display("%0t: round mismatch", $realtime);
					$display("  expected x=%h y=%h y2=%h v=%h ok=%b", exp_res.witness,
					         exp_res.response, exp_res.response_sq, exp_res.verifier,
					         exp_res.identity_ok);
					$display("  actual   x=%h y=%h y2=%h v=%h ok=%b", got.witness,
					         got.response, got.response_sq, got.verifier, got.identity_ok);
				end
				reported++;
			end
		end
	endtask

	// sample all channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_modulus    = word_t'(2);
			cfg_commit     = '0;
			cfg_negate     = 1'b0;
			round_first    = 1'b1;
			round_witness  = '0;
			round_response = '0;
			round_verifier = '0;
			round_results_q.delete();
			fail_count     = 0;
			reported       = 0;
			expected_left  = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				compare_result(m_axis_tdata);
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[AW-1:AW-2]))
					REG_MODULUS:    cfg_modulus = pwdata[WB-1:0];
					REG_COMMITMENT: cfg_commit  = pwdata[WB-1:0];
					REG_WIT_NEG:    cfg_negate  = pwdata[0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				advance_round(s_axis_tdata[WB-1:0], s_axis_tdata[WB], s_axis_tlast);
			expected_left = round_results_q.size();
		end
	end

endmodule

### tb/tb_feige_fiat_shamir_round_unit.sv
// ----------------------------------------------------------------------------
// tb_feige_fiat_shamir_round_unit
// Drives the round unit through directed rounds and random rounds under
// several register settings and idle patterns, including a long result stall.
// The checker beside the block predicts and compares; this module decides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_feige_fiat_shamir_round_unit;
	import ffsr_pkg::*;

	localparam int WB      = WORD_BITS_DEF;
	localparam int AW      = ((WB > 32) ? 3 : 2) + 2;
	localparam int DW      = (WB > 32) ? 64 : 32;
	localparam int IN_TW   = ((WB + 1 + 7) / 8) * 8;
	localparam int OUT_TW  = ((4 * WB + 1 + 7) / 8) * 8;
	// more than the longest item: open, four steps, close
	localparam int SETTLE  = 320;
	localparam int HOLD_CYCLES = 3000;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [AW-1:0]     paddr;
	logic [DW-1:0]     pwdata;
	logic [DW-1:0]     prdata;
	logic              pready;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_TW-1:0]  s_axis_tdata;   // secret_value, challenge_bit
	logic              s_axis_tlast;   // last_secret
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OUT_TW-1:0] m_axis_tdata;   // witness, response, response_squared,
	                                   // verifier_product, identity_ok

	int          fail_count;
	int          expected_left;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_req;
	int          hold_done;
	logic [31:0] cur_n;

	feige_fiat_shamir_round_unit #(.WORD_BITS(WB)) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	ffsr_checker #(.WB(WB)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.expected_left (expected_left)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// result side: random stalls, or one long hold-off counted here
	initial begin
		m_axis_tready = 1'b0;
		hold_done     = 0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_done = hold_done + 1;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// one register write transaction, setup then access
	task automatic apb_write(input reg_idx_t idx, input logic [DW-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_regs(input logic [DW-1:0] n, input logic [DW-1:0] r,
	                        input logic [DW-1:0] neg);
		apb_write(REG_MODULUS, n);
		apb_write(REG_COMMITMENT, r);
		apb_write(REG_WIT_NEG, neg);
		cur_n = {1'b0, n[WB-1:0]};
	endtask

	// one input transaction with random leading idle cycles
	task automatic send_item(input logic [WB-1:0] secret, input logic chal,
	                         input logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {chal, secret};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// drop valid, wait for every round result, then let a busy item finish
	task automatic drain_rounds();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_left != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// secrets: full range, tiny, and around the modulus
	function automatic logic [WB-1:0] pick_secret();
		logic [31:0] v;
		case ($urandom_range(3))
			0: v = $urandom_range(15);
			1: v = cur_n + $urandom_range(4) - 2;
			default: v = $urandom;
		endcase
		return v[WB-1:0];
	endfunction

	task automatic random_regs();
		logic [31:0] n;
		case ($urandom_range(4))
			0: n = $urandom_range(64, 2);
			1: n = $urandom | 32'h4000_0000;
			2: n = $urandom_range(3);
			default: n = $urandom;
		endcase
		set_regs(n, $urandom, $urandom);
	endtask

	// well-formed rounds of one to six secrets
	task automatic random_rounds(input int count);
		int sent;
		int len;
		sent = 0;
		while (sent < count) begin
			len = $urandom_range(6, 1);
			for (int k = 0; k < len; k++)
				send_item(pick_secret(), 1'($urandom_range(1)), k == len - 1);
			sent += len;
		end
	endtask

	// one phase: four register settings, about a hundred items
	task automatic run_phase(input int send_pct, input int recv_pct, input logic squeeze);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int b = 0; b < 4; b++) begin
			random_regs();
			if (squeeze && b == 1)
				hold_req = hold_req + 1;
			random_rounds(25);
			drain_rounds();
		end
	endtask

	// stimulus and verdict
	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req      = 0;
		cur_n         = 32'd2;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings, single secret round
		send_item(31'h7FFF_FFFF, 1'b1, 1'b1);
		drain_rounds();

		// largest modulus, commitment and secrets at the top of the range
		set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h0);
		send_item(31'h7FFF_FFFE, 1'b1, 1'b0);
		send_item(31'd3, 1'b0, 1'b0);
		send_item(31'h7FFF_FFFF, 1'b1, 1'b1);
		send_item(31'd5, 1'b1, 1'b1);
		drain_rounds();

		// negative witness
		apb_write(REG_WIT_NEG, 32'h1);
		send_item(31'd2, 1'b1, 1'b1);
		send_item(31'd0, 1'b0, 1'b1);
		drain_rounds();

		// negative witness with r a multiple of n
		set_regs(32'd7, 32'd7, 32'h1);
		send_item(31'd3, 1'b1, 1'b1);
		drain_rounds();

		// modulus zero and one
		set_regs(32'd0, 32'h8000_1234, 32'h0);
		send_item(31'd9, 1'b1, 1'b0);
		send_item(31'd4, 1'b1, 1'b1);
		drain_rounds();
		set_regs(32'd1, 32'd5, 32'hFFFF_FFFF);
		send_item(31'd1, 1'b1, 1'b1);
		drain_rounds();

		// smallest legal modulus
		set_regs(32'd2, 32'd1, 32'h1);
		send_item(31'd1, 1'b1, 1'b1);
		send_item(31'd2, 1'b1, 1'b1);
		drain_rounds();

		// registers rewritten in the middle of a round
		set_regs(32'd1000003, 32'd123456, 32'h0);
		send_item(31'd777, 1'b1, 1'b0);
		drain_rounds();
		set_regs(32'd65537, 32'd99, 32'h1);
		send_item(31'd12345, 1'b1, 1'b1);
		drain_rounds();

		// random phases, long result hold-off in the first
		run_phase(0, 0, 1'b1);
		run_phase(53, 0, 1'b0);
		run_phase(0, 53, 1'b0);
		run_phase(22, 22, 1'b0);

		drain_rounds();
		if (fail_count == 0 && expected_left == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
